>>> src/biquad_cascade_df2_iir_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the biquad cascade
// Short forms for the clocked implications used in the block's checks.
// ---------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_DF2_IIR_MACROS_SVH
`define BIQUAD_CASCADE_DF2_IIR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BQC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BQC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bqc_pkg.sv
// ---------------------------------------------------------------------------
// Biquad cascade package
// Formats, sequencer states and multiply-accumulate control shared by the
// biquad cascade modules.
// ---------------------------------------------------------------------------
package bqc_pkg;

  // Fixed-point formats: samples Q1.15, coefficients Q3.15, states Q9.23.
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int STATE_W   = 32;
  localparam int PROD_W    = COEF_W + STATE_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int CFG_W     = 6;
  localparam int SEC_IDX_W = 5;
  localparam int SEL_W     = 3;

  // Coefficients per section: a0, a1, a2, b0, b1, b2.
  localparam int NUM_COEFS = 6;

  // Product scaling back to Q9.23, and sample alignment to Q9.23.
  localparam int FRAC_SHIFT   = 15;
  localparam int SAMPLE_SHIFT = 8;

  // Transaction kinds.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_FILTER = 1'b1;

  // Sequencer states; ST_FETCH through ST_SUM_Y run once per section.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MUL_X,
    ST_MUL_W1A,
    ST_MUL_W0A,
    ST_SUM_W,
    ST_STORE_W,
    ST_MUL_WB,
    ST_MUL_W1B,
    ST_MUL_W0B,
    ST_SUM_Y,
    ST_FINISH,
    ST_OUTPUT
  } state_t;

  // Accumulator operation for the shared multiply-accumulate unit.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

endpackage

>>> src/bqc_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bqc_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 192,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/bqc_mac.sv
// ---------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered 18x32 product, 52-bit accumulator, and rounding with
// saturation of the accumulator back to a Q9.23 state word.
// ---------------------------------------------------------------------------
module bqc_mac (
  input  logic                                clk,
  input  bqc_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [bqc_pkg::COEF_W-1:0]   coef,
  input  logic signed [bqc_pkg::STATE_W-1:0]  operand,
  output logic signed [bqc_pkg::STATE_W-1:0]  state_val,
  output logic                                state_clip
);
  import bqc_pkg::*;

  localparam int SHR_W = ACC_W - FRAC_SHIFT;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (FRAC_SHIFT - 1);

  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic        [SHR_W-1:0]   acc_shr;
  logic [SHR_W-STATE_W:0]    acc_top;

  // Product register, then accumulate on the following cycle.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(coef) * PROD_W'(operand);
    end
    unique case (ctrl.acc_op)
      ACC_HOLD: acc <= acc;
      ACC_LOAD: acc <= ACC_W'(prod);
      ACC_ADD:  acc <= acc + ACC_W'(prod);
      ACC_SUB:  acc <= acc - ACC_W'(prod);
    endcase
  end

  // Round half up, floor shift to Q9.23 and saturate to 32 bits.
  always_comb begin
    acc_rnd    = acc + ROUND;
    acc_shr    = acc_rnd[ACC_W-1:FRAC_SHIFT];
    acc_top    = acc_shr[SHR_W-1:STATE_W-1];
    state_clip = !((&acc_top) || (~|acc_top));
    if (!state_clip) begin
      state_val = acc_shr[STATE_W-1:0];
    end else if (acc_shr[SHR_W-1]) begin
      state_val = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      state_val = {1'b0, {(STATE_W-1){1'b1}}};
    end
  end

endmodule

>>> src/biquad_cascade_df2_iir.sv
// After a filter transaction is accepted, item_stall stays high until the result
// has been handed to the output, so the block takes no new transaction while one
// is in progress; a load is taken in the idle state and leaves it there.
// Each section costs six passes through the single multiply-accumulate unit.
// After reset a sweep zeroes the coefficient and delay stores while item_stall
// is high; sections_in_use resets to 1.
// ---------------------------------------------------------------------------
// Cascaded biquad IIR filter, direct form II
// Coefficient loads and saturating fixed-point filtering through a chain of
// second-order sections, computed by a sequencer around one shared MAC.
// ---------------------------------------------------------------------------
`include "biquad_cascade_df2_iir_macros.svh"

module biquad_cascade_df2_iir #(
  parameter int MAX_SECTIONS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [bqc_pkg::CFG_W-1:0]            cfg_wr_data,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 action,
  input  logic [bqc_pkg::SEC_IDX_W-1:0]        section_index,
  input  logic [bqc_pkg::SEL_W-1:0]            coef_select,
  input  logic signed [bqc_pkg::COEF_W-1:0]    coef_value,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [bqc_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                 saturated
);
  import bqc_pkg::*;

  localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int COEF_DEPTH = NUM_COEFS * MAX_SECTIONS;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int CFG_EXT_W  = CFG_W + 1;
  // Wide enough for section_index * 6 + coef_select and for a CA_W of at most LOAD_W bits.
  localparam int LOAD_W     = 9;
  localparam int ORND_W     = STATE_W + 1;
  localparam int OSHR_W     = ORND_W - SAMPLE_SHIFT;
  localparam int OUT_ROUND  = 1 << (SAMPLE_SHIFT - 1);

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]  sections_in_use;
  logic [SEC_W-1:0]  last_idx;
  logic [SEC_W-1:0]  last_sec;
  logic [SEC_W-1:0]  sec;
  logic [CA_W-1:0]   clr_addr;
  logic [CA_W-1:0]   coef_addr;

  logic signed [STATE_W-1:0] xin;
  logic signed [STATE_W-1:0] w0;
  logic signed [STATE_W-1:0] w1;
  logic signed [STATE_W-1:0] w_new;
  logic                      sat_acc;

  logic accept;
  logic start;
  logic load_ok;
  logic coef_step;
  logic load_x;
  logic output_go;

  logic [LOAD_W-1:0] load_full;

  logic              coef_we;
  logic [CA_W-1:0]   coef_wa;
  logic [COEF_W-1:0] coef_wd;
  logic signed [COEF_W-1:0] coef_rd;

  logic               dly_we;
  logic [SEC_W-1:0]   dly_wa;
  logic [STATE_W-1:0] w0_wd;
  logic [STATE_W-1:0] w1_wd;
  logic [STATE_W-1:0] w0_rd;
  logic [STATE_W-1:0] w1_rd;

  mac_ctrl_t                 mac_ctrl;
  logic signed [STATE_W-1:0] operand;
  logic signed [STATE_W-1:0] state_val;
  logic                      state_clip;

  logic signed [ORND_W-1:0]  out_rnd;
  logic        [OSHR_W-1:0]  out_shr;
  logic [OSHR_W-SAMPLE_W:0]  out_top;
  logic                      out_clip;
  logic signed [SAMPLE_W-1:0] out_val;

  // Input handshake.
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign start      = accept && (action == ACT_FILTER);

  // Last section index from the register, with zero and overflow clamped.
  always_comb begin
    if (sections_in_use == '0) begin
      last_idx = '0;
    end else if (CFG_EXT_W'(sections_in_use) > CFG_EXT_W'(MAX_SECTIONS)) begin
      last_idx = SEC_W'(MAX_SECTIONS - 1);
    end else begin
      last_idx = SEC_W'(sections_in_use - 1'b1);
    end
  end

  // Coefficient load address and range check.
  assign load_full = LOAD_W'(section_index) * LOAD_W'(NUM_COEFS) + LOAD_W'(coef_select);
  assign load_ok   = (coef_select < SEL_W'(NUM_COEFS)) &&
                     (CFG_EXT_W'(section_index) < CFG_EXT_W'(MAX_SECTIONS));

  // Coefficient store write port: clearing sweep or load transaction.
  always_comb begin
    if (state == ST_CLEAR) begin
      coef_we = 1'b1;
      coef_wa = clr_addr;
      coef_wd = '0;
    end else begin
      coef_we = accept && (action == ACT_LOAD) && load_ok;
      coef_wa = load_full[CA_W-1:0];
      coef_wd = coef_value;
    end
  end

  // Delay store write port: clearing sweep or the shift of one section.
  always_comb begin
    if (state == ST_CLEAR) begin
      dly_we = (clr_addr < CA_W'(MAX_SECTIONS));
      dly_wa = clr_addr[SEC_W-1:0];
      w0_wd  = '0;
      w1_wd  = '0;
    end else begin
      dly_we = (state == ST_MUL_WB);
      dly_wa = sec;
      w0_wd  = w1;
      w1_wd  = w_new;
    end
  end

  bqc_ram #(
    .WIDTH(COEF_W),
    .DEPTH(COEF_DEPTH)
  ) u_coef_ram (
    .clk    (clk),
    .wr_en  (coef_we),
    .wr_addr(coef_wa),
    .wr_data(coef_wd),
    .rd_addr(coef_addr),
    .rd_data(coef_rd)
  );

  bqc_ram #(
    .WIDTH(STATE_W),
    .DEPTH(MAX_SECTIONS)
  ) u_w0_ram (
    .clk    (clk),
    .wr_en  (dly_we),
    .wr_addr(dly_wa),
    .wr_data(w0_wd),
    .rd_addr(sec),
    .rd_data(w0_rd)
  );

  bqc_ram #(
    .WIDTH(STATE_W),
    .DEPTH(MAX_SECTIONS)
  ) u_w1_ram (
    .clk    (clk),
    .wr_en  (dly_we),
    .wr_addr(dly_wa),
    .wr_data(w1_wd),
    .rd_addr(sec),
    .rd_data(w1_rd)
  );

  bqc_mac u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .coef      (coef_rd),
    .operand   (operand),
    .state_val (state_val),
    .state_clip(state_clip)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, MAC control and sequencing strobes.
  always_comb begin
    state_next = state;
    mac_ctrl   = '{mul_en: 1'b0, acc_op: ACC_HOLD};
    operand    = xin;
    coef_step  = 1'b0;
    load_x     = 1'b0;
    output_go  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == CA_W'(COEF_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        coef_step  = 1'b1;
        load_x     = (sec != '0);
        state_next = ST_MUL_X;
      end
      ST_MUL_X: begin
        mac_ctrl.mul_en = 1'b1;
        operand         = xin;
        coef_step       = 1'b1;
        state_next      = ST_MUL_W1A;
      end
      ST_MUL_W1A: begin
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_LOAD};
        operand    = w1;
        coef_step  = 1'b1;
        state_next = ST_MUL_W0A;
      end
      ST_MUL_W0A: begin
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_SUB};
        operand    = w0;
        state_next = ST_SUM_W;
      end
      ST_SUM_W: begin
        mac_ctrl.acc_op = ACC_SUB;
        state_next      = ST_STORE_W;
      end
      ST_STORE_W: begin
        coef_step  = 1'b1;
        state_next = ST_MUL_WB;
      end
      ST_MUL_WB: begin
        mac_ctrl.mul_en = 1'b1;
        operand         = w_new;
        coef_step       = 1'b1;
        state_next      = ST_MUL_W1B;
      end
      ST_MUL_W1B: begin
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_LOAD};
        operand    = w1;
        coef_step  = 1'b1;
        state_next = ST_MUL_W0B;
      end
      ST_MUL_W0B: begin
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_ADD};
        operand    = w0;
        state_next = ST_SUM_Y;
      end
      ST_SUM_Y: begin
        mac_ctrl.acc_op = ACC_ADD;
        state_next      = (sec == last_sec) ? ST_FINISH : ST_FETCH;
      end
      ST_FINISH: begin
        load_x     = 1'b1;
        state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (!result_valid || !result_stall) begin
          output_go  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control registers: configuration, clearing sweep, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      sections_in_use <= CFG_W'(1);
      clr_addr        <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sections_in_use <= cfg_wr_data;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (output_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Output rounding: Q9.23 to Q1.15 with saturation.
  always_comb begin
    out_rnd  = ORND_W'(xin) + ORND_W'(OUT_ROUND);
    out_shr  = out_rnd[ORND_W-1:SAMPLE_SHIFT];
    out_top  = out_shr[OSHR_W-1:SAMPLE_W-1];
    out_clip = !((&out_top) || (~|out_top));
    if (!out_clip) begin
      out_val = out_shr[SAMPLE_W-1:0];
    end else if (out_shr[OSHR_W-1]) begin
      out_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      out_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    if (start) begin
      xin       <= {{(STATE_W-SAMPLE_W-SAMPLE_SHIFT){sample_in[SAMPLE_W-1]}},
                    sample_in, {SAMPLE_SHIFT{1'b0}}};
      coef_addr <= '0;
      sec       <= '0;
      last_sec  <= last_idx;
      sat_acc   <= 1'b0;
    end
    if (coef_step) begin
      coef_addr <= coef_addr + 1'b1;
    end
    if (state == ST_MUL_X) begin
      w0 <= w0_rd;
      w1 <= w1_rd;
    end
    if (state == ST_STORE_W) begin
      w_new   <= state_val;
      sat_acc <= sat_acc | state_clip;
    end
    if (load_x) begin
      xin     <= state_val;
      sat_acc <= sat_acc | state_clip;
    end
    if ((state == ST_SUM_Y) && (sec != last_sec)) begin
      sec <= sec + 1'b1;
    end
    if (output_go) begin
      sample_out <= out_val;
      saturated  <= sat_acc | out_clip;
    end
  end

  // Checks on the sequencer.
  `BQC_ASSERT_SAME(a_load_only_idle, clk, rst, coef_we && (state != ST_CLEAR), (state == ST_IDLE) && (action == ACT_LOAD), "coefficient write outside an idle load")
  `BQC_ASSERT_SAME(a_delay_write_phase, clk, rst, dly_we, (state == ST_MUL_WB) || (state == ST_CLEAR), "delay write outside its phase")
  `BQC_ASSERT_SAME(a_section_bound, clk, rst, (state != ST_CLEAR) && (state != ST_IDLE), sec <= last_sec, "section counter past the last section")
  `BQC_ASSERT_NEXT(a_result_loaded, clk, rst, output_go, result_valid && (state == ST_IDLE), "result not presented after output step")
  `BQC_ASSERT_SAME(a_quiet_clear, clk, rst, state == ST_CLEAR, !result_valid && item_stall, "activity during clearing sweep")

endmodule
